// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the next cycle
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/lzwe_pkg.sv =====
// Shared types and constants of the LZW byte stream encoder
`timescale 1ns / 1ps
`default_nettype none
package lzwe_pkg;
    localparam int unsigned CODE_W      = 12;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned FIRST_FREE  = 256;
    typedef logic [CODE_W-1:0] t_code;
    typedef logic [BYTE_W-1:0] t_byte;
endpackage
`default_nettype wire

// ===== rtl/lzw_byte_stream_encoder_unit.sv =====
// Top level of the LZW byte stream encoder
`timescale 1ns / 1ps
`default_nettype none
// LZW encoder over bytes with codes 0..255 implied. The search walks the
// entries from code 256 upward through one compare unit, and each probe
// reads a word of the pair memory (registered read) and then compares it.
// The search stops at the first match, or one probe past the last live entry
// on a miss. A byte that starts a stream needs no search, and unless it is
// also the last byte the block stays ready. Up to two codes are then
// delivered through the output register, one per handshake, and a stalled
// output holds the block until it is taken. No clearing pass is needed: only
// entries below the next free code are ever compared.
module lzw_byte_stream_encoder_unit #(
    parameter int unsigned DICTIONARY_ENTRIES = 4096
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire  [7:0]              i_byte_in,
    input  wire                     i_last_byte,
    output logic                    o_valid,
    input  wire                     i_ready,
    output logic [11:0]             o_code_out,
    output logic                    o_stream_end
);
    localparam int unsigned AW = $clog2(DICTIONARY_ENTRIES);
    localparam int unsigned KW = AW + 8;
    localparam logic [AW:0] FIRST = (AW+1)'(lzwe_pkg::FIRST_FREE);
    localparam logic [AW:0] LIMIT = (AW+1)'(DICTIONARY_ENTRIES);

    typedef enum logic [2:0] {S_IDLE, S_READ, S_CMP, S_EMIT1, S_EMIT2} t_state;

    t_state              r_state;
    logic [AW-1:0]       r_prefix;
    logic                r_prefix_valid;
    logic [AW:0]         r_next;
    logic [AW:0]         r_scan;
    logic [7:0]          r_byte;
    logic                r_last;
    logic [KW-1:0]       r_rdata;
    logic [11:0]         r_code2;
    logic [KW-1:0]       r_mem [DICTIONARY_ENTRIES];

    logic [KW-1:0] w_key;
    assign w_key = {r_prefix, r_byte};

    // pair memory: registered read at the scan pointer, write on miss
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[r_scan[AW-1:0]];
        if (r_state == S_CMP && r_scan >= r_next)
            r_mem[r_next[AW-1:0]] <= w_key;
    end

    assign o_ready = (r_state == S_IDLE);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_prefix_valid <= 1'b0;
            r_prefix       <= '0;
            r_next         <= FIRST;
            r_scan         <= FIRST;
            o_valid        <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_byte <= i_byte_in;
                        r_last <= i_last_byte;
                        r_scan <= FIRST;
                        if (!r_prefix_valid) begin
                            r_prefix       <= AW'(i_byte_in);
                            r_prefix_valid <= 1'b1;
                            if (i_last_byte) begin
                                o_valid      <= 1'b1;
                                o_code_out   <= 12'(i_byte_in);
                                o_stream_end <= 1'b1;
                                r_state      <= S_EMIT2;
                            end
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_scan >= r_next) begin
                        // miss: emit prefix, add pair, restart from byte
                        o_valid      <= 1'b1;
                        o_code_out   <= 12'(r_prefix);
                        o_stream_end <= 1'b0;
                        r_prefix     <= AW'(r_byte);
                        r_code2      <= 12'(r_byte);
                        r_next       <= (r_next + 1'b1 >= LIMIT) ? FIRST : r_next + 1'b1;
                        r_state      <= S_EMIT1;
                    end else if (r_rdata == w_key) begin
                        r_prefix <= r_scan[AW-1:0];
                        if (r_last) begin
                            o_valid      <= 1'b1;
                            o_code_out   <= 12'(r_scan);
                            o_stream_end <= 1'b1;
                            r_state      <= S_EMIT2;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_scan  <= r_scan + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_EMIT1: begin
                    if (i_ready) begin
                        if (r_last) begin
                            o_code_out   <= r_code2;
                            o_stream_end <= 1'b1;
                            r_state      <= S_EMIT2;
                        end else begin
                            o_valid <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_EMIT2: begin
                    if (i_ready) begin
                        o_valid        <= 1'b0;
                        r_prefix_valid <= 1'b0;
                        r_prefix       <= '0;
                        r_next         <= FIRST;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/lzwe_checker.sv =====
// Port-level checker for the LZW byte stream encoder
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lzwe_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_valid,
    input wire        o_ready,
    input wire        o_valid,
    input wire        i_ready,
    input wire [11:0] o_code_out,
    input wire        o_stream_end
);
    // never ready for input while a result is pending
    `AST_IMPLY(a_no_overlap, i_clk, i_rst_n, o_valid, !o_ready)
    // a stalled result holds
    `AST_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_code_out))
    // after the final code is taken the block is ready again
    `AST_NEXT(a_end_ready, i_clk, i_rst_n, o_valid && i_ready && o_stream_end, o_ready)
    // after an accepted request, ready and a valid result are not both high
    `AST_NEXT(a_busy, i_clk, i_rst_n, i_valid && o_ready, !o_ready || !o_valid)
endmodule
bind lzw_byte_stream_encoder_unit lzwe_checker u_lzwe_checker (.*);
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for the LZW byte stream encoder
`timescale 1ns / 1ps
module testbench;
    localparam int unsigned DICT_DEPTH = 4096;
    localparam int unsigned N_RANDOM   = 1800;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    lzwe_pkg::t_byte   i_byte_in;
    logic              i_last_byte;
    logic              o_valid;
    logic              i_ready;
    lzwe_pkg::t_code   o_code_out;
    logic              o_stream_end;

    lzw_byte_stream_encoder_unit #(.DICTIONARY_ENTRIES(DICT_DEPTH)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_byte_in    (i_byte_in),
        .i_last_byte  (i_last_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_code_out   (o_code_out),
        .o_stream_end (o_stream_end)
    );

    // Directed stimulus row: expected codes typed in where has_exp is set
    typedef struct {
        lzwe_pkg::t_byte data;
        logic            last;
        bit              has_exp;
        int              n_codes;
        lzwe_pkg::t_code code0;
        logic            end0;
        lzwe_pkg::t_code code1;
        logic            end1;
    } t_row;

    // Encoder shadow state
    lzwe_pkg::t_code cur_prefix;
    bit              have_prefix;
    int unsigned     free_code;
    logic [19:0]     pair_mem [0:DICT_DEPTH-1];

    // Codes still owed by the block, oldest first
    lzwe_pkg::t_code pending_code [$];
    logic            pending_end  [$];

    int          n_sent;
    int          n_checked;
    int          n_errors;
    bit          quiet;
    int          rdy_stall;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("timeout with %0d codes outstanding", pending_code.size());
        $display("FAIL");
        $finish;
    end

    // Shadow encoder: advances state, returns emitted codes
    function automatic int encode_byte(input lzwe_pkg::t_byte data, input logic last,
                                       output lzwe_pkg::t_code c0, output logic e0,
                                       output lzwe_pkg::t_code c1, output logic e1);
        logic [19:0] pair;
        bit          hit;
        int          n;
        n = 0;
        hit = 0;
        c0 = '0; e0 = 1'b0; c1 = '0; e1 = 1'b0;
        if (!have_prefix) begin
            cur_prefix  = lzwe_pkg::t_code'(data);
            have_prefix = 1;
        end else begin
            pair = {cur_prefix, data};
            for (int unsigned c = lzwe_pkg::FIRST_FREE; c < free_code; c++) begin
                if (!hit && pair_mem[c] == pair) begin
                    hit = 1;
                    cur_prefix = lzwe_pkg::t_code'(c);
                end
            end
            if (!hit) begin
                c0 = cur_prefix; e0 = 1'b0; n = 1;
                pair_mem[free_code] = pair;
                free_code++;
                if (free_code >= DICT_DEPTH) free_code = lzwe_pkg::FIRST_FREE;
                cur_prefix = lzwe_pkg::t_code'(data);
            end
        end
        if (last) begin
            if (n == 0) begin c0 = cur_prefix; e0 = 1'b1; end
            else begin c1 = cur_prefix; e1 = 1'b1; end
            n++;
            cur_prefix  = '0;
            have_prefix = 0;
            free_code   = lzwe_pkg::FIRST_FREE;
        end
        return n;
    endfunction

    // Present one request and hold it until accepted
    task automatic send_byte(input lzwe_pkg::t_byte data, input logic last, input t_row row);
        lzwe_pkg::t_code c0, c1;
        logic            e0, e1;
        int              n;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        n = encode_byte(data, last, c0, e0, c1, e1);
        if (row.has_exp) begin
            n = row.n_codes;
            c0 = row.code0; e0 = row.end0; c1 = row.code1; e1 = row.end1;
        end
        if (n > 0) begin pending_code.push_back(c0); pending_end.push_back(e0); end
        if (n > 1) begin pending_code.push_back(c1); pending_end.push_back(e1); end
        i_valid     <= 1'b1;
        i_byte_in   <= data;
        i_last_byte <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        n_sent++;
    endtask

    // Output side: random stall bursts on i_ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            rdy_stall <= 0;
        end else if (quiet) begin
            i_ready <= 1'b1;
        end else if (rdy_stall > 0) begin
            i_ready   <= 1'b0;
            rdy_stall <= rdy_stall - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            i_ready   <= 1'b0;
            rdy_stall <= $urandom_range(0, 2);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Compare each delivered code against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_code.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected code %0d end %0b", o_code_out, o_stream_end);
            end else begin
                if (o_code_out !== pending_code[0] || o_stream_end !== pending_end[0]) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("code mismatch: expected %0d/%0b got %0d/%0b",
                                 pending_code[0], pending_end[0], o_code_out, o_stream_end);
                end
                void'(pending_code.pop_front());
                void'(pending_end.pop_front());
                n_checked++;
            end
        end
    end

    initial begin
        t_row  dir_rows [] = '{
            '{8'h00, 1'b1, 1, 1, 12'd0,   1'b1, 12'd0,  1'b0},  // lone byte, lowest
            '{8'hFF, 1'b1, 1, 1, 12'd255, 1'b1, 12'd0,  1'b0},  // lone byte, highest
            '{8'h41, 1'b0, 1, 0, 12'd0,   1'b0, 12'd0,  1'b0},  // first byte, no code
            '{8'h41, 1'b0, 1, 1, 12'h41,  1'b0, 12'd0,  1'b0},  // miss adds code 256
            '{8'h41, 1'b0, 1, 0, 12'd0,   1'b0, 12'd0,  1'b0},  // hit on 256
            '{8'h41, 1'b1, 1, 2, 12'd256, 1'b0, 12'h41, 1'b1},  // miss on last byte
            '{8'h80, 1'b0, 0, 0, 12'd0,   1'b0, 12'd0,  1'b0},
            '{8'h01, 1'b0, 0, 0, 12'd0,   1'b0, 12'd0,  1'b0},
            '{8'h80, 1'b0, 0, 0, 12'd0,   1'b0, 12'd0,  1'b0},
            '{8'h01, 1'b0, 0, 0, 12'd0,   1'b0, 12'd0,  1'b0},
            '{8'h80, 1'b0, 0, 0, 12'd0,   1'b0, 12'd0,  1'b0},
            '{8'h01, 1'b1, 0, 0, 12'd0,   1'b0, 12'd0,  1'b0},  // ends on a hit
            '{8'h7F, 1'b0, 1, 0, 12'd0,   1'b0, 12'd0,  1'b0},
            '{8'h7F, 1'b1, 1, 2, 12'h7F,  1'b0, 12'h7F, 1'b1},
            '{8'hAA, 1'b0, 0, 0, 12'd0,   1'b0, 12'd0,  1'b0},
            '{8'h55, 1'b0, 0, 0, 12'd0,   1'b0, 12'd0,  1'b0},
            '{8'hAA, 1'b0, 0, 0, 12'd0,   1'b0, 12'd0,  1'b0},
            '{8'h55, 1'b0, 0, 0, 12'd0,   1'b0, 12'd0,  1'b0},
            '{8'hAA, 1'b0, 0, 0, 12'd0,   1'b0, 12'd0,  1'b0},
            '{8'h55, 1'b1, 0, 0, 12'd0,   1'b0, 12'd0,  1'b0}
        };
        t_row            no_exp;
        int              len;
        int              base;
        bit              narrow;
        lzwe_pkg::t_byte data;

        no_exp      = '{8'h00, 1'b0, 0, 0, 12'd0, 1'b0, 12'd0, 1'b0};
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_byte_in   = '0;
        i_last_byte = 1'b0;
        quiet       = 0;
        n_sent      = 0;
        n_checked   = 0;
        n_errors    = 0;
        cur_prefix  = '0;
        have_prefix = 0;
        free_code   = lzwe_pkg::FIRST_FREE;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i]);

        // Random streams; small alphabets give long dictionary chains
        while (n_sent < N_RANDOM + dir_rows.size()) begin
            if (n_sent > dir_rows.size() + N_RANDOM * 9 / 10) quiet = 1;
            len    = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 250)
                                                  : $urandom_range(1, 40);
            narrow = ($urandom_range(0, 3) != 0);
            base   = $urandom_range(0, 252);
            for (int k = 0; k < len; k++) begin
                data = narrow ? lzwe_pkg::t_byte'(base + $urandom_range(0, 3))
                              : lzwe_pkg::t_byte'($urandom_range(0, 255));
                send_byte(data, k == len - 1, no_exp);
            end
        end
        i_valid <= 1'b0;

        while (pending_code.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("sent %0d bytes in short and long streams, checked %0d codes",
                 n_sent, n_checked);
        if (n_errors == 0 && pending_code.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("FAIL");
        end
        $finish;
    end
endmodule
